// ===== rtl/note_string_parser_core_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef NOTE_STRING_PARSER_CORE_ASSERT_SVH
`define NOTE_STRING_PARSER_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define NSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsp assertion failed");

// Next-cycle implication checked outside reset.
`define NSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsp assertion failed");

// Next-cycle implication that is also checked during reset.
`define NSP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("nsp assertion failed");

`endif

// ===== rtl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Types, constants and helper functions of the note string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

    localparam logic [15:0] MAX_NOTES_RESET = 16'd256;
    localparam int          OUT_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_SHARP = 8'h23;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Character class of one input item.
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_DIGIT,
        CLS_NOTE,
        CLS_SHARP,
        CLS_AT
    } char_class_t;

    // Decoded character, handed from the decoder to the parser.
    typedef struct packed {
        char_class_t cls;
        logic [3:0]  semitone;
        logic [3:0]  digit;
        logic        e_or_h;
    } char_info_t;

    // One result item.
    typedef struct packed {
        logic [15:0] note_word;
        logic        note_valid;
        logic        last_of_string;
        logic [15:0] note_count;
    } result_t;

    // Octave step for a digit: (d + 1) * 12, at most 120 for a decimal digit.
    function automatic logic [7:0] octave_step(input logic [3:0] d);
        logic [7:0] dp1;
        dp1 = {4'd0, d} + 8'd1;
        return {dp1[4:0], 3'b000} + {dp1[5:0], 2'b00};
    endfunction

    // Amplitude accumulation: (a * 10 + d) modulo 1024.
    function automatic logic [9:0] amp_accum(input logic [9:0] a, input logic [3:0] d);
        logic [13:0] sum;
        sum = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {10'd0, d};
        return sum[9:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nsp_decode.sv =====
// ----------------------------------------------------------------------------
// nsp_decode
// Classifies one character code, folding lower case onto upper case.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_decode
    import nsp_pkg::*;
(
    input  wire logic [7:0] char_code,
    output char_info_t      info
);

    logic [7:0] upper;

    always_comb begin
        if (char_code inside {[8'h61:8'h7A]}) begin
            upper = char_code - 8'h20;
        end else begin
            upper = char_code;
        end
    end

    always_comb begin
        info.cls      = CLS_OTHER;
        info.semitone = 4'd0;
        info.digit    = char_code[3:0];
        info.e_or_h   = 1'b0;
        if (char_code inside {[8'h30:8'h39]}) begin
            info.cls   = CLS_DIGIT;
            info.digit = 4'(char_code - CHAR_ZERO);
        end else if (char_code == CHAR_SHARP) begin
            info.cls = CLS_SHARP;
        end else if (char_code == CHAR_AT) begin
            info.cls = CLS_AT;
        end else begin
            case (upper)
                8'h43: begin info.cls = CLS_NOTE; info.semitone = 4'd0; end
                8'h44: begin info.cls = CLS_NOTE; info.semitone = 4'd2; end
                8'h45: begin
                    info.cls = CLS_NOTE; info.semitone = 4'd4; info.e_or_h = 1'b1;
                end
                8'h46: begin info.cls = CLS_NOTE; info.semitone = 4'd5; end
                8'h47: begin info.cls = CLS_NOTE; info.semitone = 4'd7; end
                8'h41: begin info.cls = CLS_NOTE; info.semitone = 4'd9; end
                8'h48: begin
                    info.cls = CLS_NOTE; info.semitone = 4'd11; info.e_or_h = 1'b1;
                end
                default: info.cls = CLS_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nsp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// nsp_out_fifo
// Small result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_out_fifo
    import nsp_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH_DEFAULT
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push_one,
    input  wire logic    push_two,
    input  result_t      push_data0,
    input  result_t      push_data1,
    output logic         room_two,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign room_two     = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_two) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
            count_next  = count_next + CW'(2);
        end else if (push_one) begin
            wr_ptr_next = wr_ptr_plus1;
            count_next  = count_next + CW'(1);
        end
        if (pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
            count_next  = count_next - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_one || push_two) begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_two) begin
            mem_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/note_string_parser_core.sv =====
// ----------------------------------------------------------------------------
// note_string_parser_core
// Melody string parser: characters in, note words out.
// ----------------------------------------------------------------------------
// Usage:
// While s_ready is high, the s_ channel takes one character item per cycle
// (s_char_code), or an end item (s_end_of_string high) that closes the
// string. The m_ channel gives note items: a note word with its running note
// count, flagged with m_last_of_string on the final item of each string. A
// string that ends with no note pending gives a bare terminator item with
// m_note_valid low. The cfg_ channel writes max_notes; it is always ready.
// The user must write it only while the block is idle; the block itself
// does not enforce this. An item's results are registered in the result queue
// when accepted. Throughput: one item per cycle, sustained, as long
// as the receiver takes results; an item can cause at most two results, and
// the input is taken whenever the result queue has room for two.
// Reset clears all per-string state, empties the result queue and loads
// max_notes with 256. When the receiver stalls, results collect in the
// queue and s_ready falls once fewer than two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module note_string_parser_core
    import nsp_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Character items.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_end_of_string,
    // Result items.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_note_word,
    output logic             m_note_valid,
    output logic             m_last_of_string,
    output logic [15:0]      m_note_count,
    // Configuration write of max_notes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_max_notes
);

    // Parser state registers.
    logic [15:0] max_notes_reg;
    logic [15:0] pending_reg, pending_next;
    logic        have_reg, have_next;
    logic        eh_reg, eh_next;
    logic        amp_mode_reg, amp_mode_next;
    logic [1:0]  amp_cnt_reg, amp_cnt_next;
    logic [9:0]  amp_val_reg, amp_val_next;
    logic [15:0] started_reg, started_next;
    logic        limit_reg, limit_next;

    char_info_t  info;
    logic        accept;
    logic [15:0] closed_note;
    logic [15:0] started_inc;
    logic        push_one, push_two;
    result_t     res0, res1, out_data;
    logic        room_two;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign s_ready   = room_two;

    nsp_decode u_decode (
        .char_code (s_char_code),
        .info      (info)
    );

    // The pending note with a collected amplitude ORed into its high byte.
    always_comb begin
        if (amp_mode_reg && have_reg) begin
            closed_note = pending_reg | {amp_val_reg[7:0], 8'h00};
        end else begin
            closed_note = pending_reg;
        end
    end

    assign started_inc = started_reg + 16'd1;

    // Next-state and result logic for one accepted item.
    always_comb begin
        pending_next  = pending_reg;
        have_next     = have_reg;
        eh_next       = eh_reg;
        amp_mode_next = amp_mode_reg;
        amp_cnt_next  = amp_cnt_reg;
        amp_val_next  = amp_val_reg;
        started_next  = started_reg;
        limit_next    = limit_reg;
        push_one      = 1'b0;
        push_two      = 1'b0;
        res0          = '0;
        res1          = '0;

        if (accept) begin
            if (s_end_of_string) begin
                // The end item closes the amplitude, flushes the pending note
                // (or a bare terminator) and starts a fresh string.
                push_one            = 1'b1;
                res0.note_word      = have_reg ? closed_note : 16'd0;
                res0.note_valid     = have_reg;
                res0.last_of_string = 1'b1;
                res0.note_count     = started_reg;
                pending_next        = '0;
                have_next           = 1'b0;
                eh_next             = 1'b0;
                amp_mode_next       = 1'b0;
                amp_cnt_next        = '0;
                amp_val_next        = '0;
                started_next        = '0;
                limit_next          = 1'b0;
            end else if (!limit_reg) begin
                if (info.cls == CLS_DIGIT) begin
                    if (amp_mode_reg) begin
                        // Digits beyond the third are dropped.
                        if (amp_cnt_reg != 2'd3) begin
                            amp_val_next = amp_accum(amp_val_reg, info.digit);
                            amp_cnt_next = amp_cnt_reg + 2'd1;
                        end
                    end else if (have_reg) begin
                        pending_next = pending_reg + {8'd0, octave_step(info.digit)};
                    end
                end else begin
                    // Any non-digit ends amplitude collection first.
                    pending_next  = closed_note;
                    amp_mode_next = 1'b0;
                    amp_cnt_next  = '0;
                    amp_val_next  = '0;
                    case (info.cls)
                        CLS_NOTE: begin
                            res0.note_word  = closed_note;
                            res0.note_valid = 1'b1;
                            res0.note_count = started_reg;
                            started_next    = started_inc;
                            pending_next    = {12'd0, info.semitone};
                            eh_next         = info.e_or_h;
                            res1.note_word  = {12'd0, info.semitone};
                            res1.note_valid = 1'b1;
                            res1.note_count = started_inc;
                            if (started_inc >= max_notes_reg) begin
                                // Limit hit: the new note leaves at once and
                                // input is dropped until the end item.
                                have_next  = 1'b0;
                                limit_next = 1'b1;
                                if (have_reg) begin
                                    push_two = 1'b1;
                                end else begin
                                    push_one = 1'b1;
                                    res0     = res1;
                                end
                            end else begin
                                have_next = 1'b1;
                                push_one  = have_reg;
                            end
                        end
                        CLS_SHARP: begin
                            if (have_reg && !eh_reg) begin
                                pending_next = closed_note + 16'd1;
                            end
                        end
                        CLS_AT: begin
                            amp_mode_next = have_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_notes_reg <= MAX_NOTES_RESET;
            pending_reg   <= '0;
            have_reg      <= 1'b0;
            eh_reg        <= 1'b0;
            amp_mode_reg  <= 1'b0;
            amp_cnt_reg   <= '0;
            amp_val_reg   <= '0;
            started_reg   <= '0;
            limit_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_notes_reg <= cfg_max_notes;
            end
            pending_reg  <= pending_next;
            have_reg     <= have_next;
            eh_reg       <= eh_next;
            amp_mode_reg <= amp_mode_next;
            amp_cnt_reg  <= amp_cnt_next;
            amp_val_reg  <= amp_val_next;
            started_reg  <= started_next;
            limit_reg    <= limit_next;
        end
    end

    nsp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_one   (push_one),
        .push_two   (push_two),
        .push_data0 (res0),
        .push_data1 (res1),
        .room_two   (room_two),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_note_word      = out_data.note_word;
    assign m_note_valid     = out_data.note_valid;
    assign m_last_of_string = out_data.last_of_string;
    assign m_note_count     = out_data.note_count;

endmodule

`default_nettype wire

// ===== rtl/nsp_checker.sv =====
// ----------------------------------------------------------------------------
// nsp_checker
// Port-level checks of the note string parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "note_string_parser_core_assert.svh"

module nsp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_note_word,
    input wire logic        m_note_valid,
    input wire logic        m_last_of_string,
    input wire logic [15:0] m_note_count
);

    logic        bare_item;
    logic        bare_ok;
    logic        note_item;
    logic        stall;
    logic [33:0] out_item;

    assign bare_item = m_valid && !m_note_valid;
    assign bare_ok   = m_last_of_string && (m_note_word == 16'd0);
    assign note_item = m_valid && m_note_valid;
    assign stall     = m_valid && !m_ready;
    assign out_item  = {m_note_word, m_note_valid, m_last_of_string, m_note_count};

    // A bare terminator always closes a string and carries an empty word.
    `NSP_ASSERT_IMP(a_bare_term, aclk, aresetn, bare_item, bare_ok)

    // A note inside a string has been counted.
    `NSP_ASSERT_IMP(a_note_counted, aclk, aresetn, note_item, m_note_count != 16'd0)

    // A stalled result holds.
    `NSP_ASSERT_NXT(a_out_hold, aclk, aresetn, stall, m_valid && $stable(out_item))

    // Reset empties the result queue.
    `NSP_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind note_string_parser_core nsp_checker u_nsp_checker (.*);

`default_nettype wire
